// ===== hw/rtl/ptrie_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ptrie_pkg;

    // node pool and alphabet geometry
    localparam int NODE_COUNT     = 1024;
    localparam int NODE_BITS      = $clog2(NODE_COUNT);
    localparam int FREE_BITS      = NODE_BITS + 1;
    localparam int ALPHABET_SIZE  = 26;
    localparam int SYM_BITS       = 5;
    localparam int COUNT_BITS     = 16;
    localparam int LINK_DEPTH     = NODE_COUNT * ALPHABET_SIZE;
    localparam int LINK_ADDR_BITS = $clog2(LINK_DEPTH);

    // word operations
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_EXACT  = 2'd1,
        OP_PREFIX = 2'd2,
        OP_ERASE  = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_MISSING = 2'd1,
        STATUS_FULL    = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DECIDE,
        S_UPDATE,
        S_FINISH,
        S_RESULT
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ptrie_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptrie_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ptrie_sat_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptrie_sat_unit
    import ptrie_pkg::*;
(
    input  wire logic [COUNT_BITS-1:0] value,
    input  wire logic                  dec,
    output logic      [COUNT_BITS-1:0] result
);

    // saturating step up or down
    always_comb
    begin
        if (dec)
        begin
            result = (value == '0) ? '0 : value - COUNT_BITS'(1);
        end
        else
        begin
            result = (value == '1) ? '1 : value + COUNT_BITS'(1);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/prefix_counting_trie.sv =====
`timescale 1ns / 1ps
`default_nettype none

// After its transfer a letter keeps busy high through the child-link read, a decide step
// and a finish step, with an update step before the finish when an insert or erase moves
// on, whose prefix count is read, stepped in the single saturating unit and written back;
// a final letter adds a result step and its result strobes on done the cycle after; a letter
// after a broken path or a full pool, or outside the alphabet, goes straight to the finish.
// Reset is asynchronous, then a clearing pass over the link and count memories with busy
// high. done is a one-cycle strobe; the receiver cannot stall.
module prefix_counting_trie
    import ptrie_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  op,
    input  wire logic [4:0]  symbol,
    input  wire logic        last,
    output logic             done,
    output logic [15:0]      count,
    output logic [1:0]       status
);

    state_t state_reg, state_next;

    logic [LINK_ADDR_BITS-1:0] clear_idx_reg, clear_idx_next;
    logic [FREE_BITS-1:0]      next_free_reg, next_free_next;
    logic [NODE_BITS-1:0]      cursor_reg, cursor_next;
    logic                      broken_reg, broken_next;
    logic                      full_reg, full_next;
    op_t                       op_reg, op_next;
    logic                      last_reg, last_next;
    logic [LINK_ADDR_BITS-1:0] slot_reg, slot_next;
    logic                      done_reg, done_next;
    logic [COUNT_BITS-1:0]     count_reg, count_next;
    status_t                   status_reg, status_next;

    logic                      accept;
    logic                      skip;
    logic                      bad_sym;
    logic [NODE_BITS-1:0]      nxt;
    logic                      link_zero;

    logic                      link_we;
    logic [LINK_ADDR_BITS-1:0] link_waddr;
    logic [NODE_BITS-1:0]      link_wdata;
    logic [NODE_BITS-1:0]      link_rdata;

    logic                      pre_we;
    logic [NODE_BITS-1:0]      pre_waddr;
    logic [COUNT_BITS-1:0]     pre_wdata;
    logic [NODE_BITS-1:0]      pre_raddr;
    logic [COUNT_BITS-1:0]     pre_rdata;

    logic                      end_we;
    logic [NODE_BITS-1:0]      end_waddr;
    logic [COUNT_BITS-1:0]     end_wdata;
    logic [COUNT_BITS-1:0]     end_rdata;

    logic [COUNT_BITS-1:0]     sat_in;
    logic                      sat_dec;
    logic [COUNT_BITS-1:0]     sat_out;

    logic                      clear_counts;
    logic                      word_ok;

    // memories and shared count unit
    ptrie_ram #(.DEPTH(LINK_DEPTH), .WIDTH(NODE_BITS)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (slot_reg),
        .rdata (link_rdata)
    );

    ptrie_ram #(.DEPTH(NODE_COUNT), .WIDTH(COUNT_BITS)) u_prefix_ram (
        .clk   (clk),
        .we    (pre_we),
        .waddr (pre_waddr),
        .wdata (pre_wdata),
        .raddr (pre_raddr),
        .rdata (pre_rdata)
    );

    ptrie_ram #(.DEPTH(NODE_COUNT), .WIDTH(COUNT_BITS)) u_end_ram (
        .clk   (clk),
        .we    (end_we),
        .waddr (end_waddr),
        .wdata (end_wdata),
        .raddr (cursor_reg),
        .rdata (end_rdata)
    );

    ptrie_sat_unit u_sat (
        .value  (sat_in),
        .dec    (sat_dec),
        .result (sat_out)
    );

    // common decodes
    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign bad_sym   = (symbol >= SYM_BITS'(ALPHABET_SIZE));
    assign skip      = broken_reg || full_reg || bad_sym;
    assign link_zero = (link_rdata == '0);
    assign nxt       = link_zero ? next_free_reg[NODE_BITS-1:0] : link_rdata;
    assign clear_counts = (clear_idx_reg < LINK_ADDR_BITS'(NODE_COUNT));
    assign word_ok   = !broken_reg && !full_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clear_idx_reg == LINK_ADDR_BITS'(LINK_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = skip ? S_FINISH : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (link_zero && (op_reg != OP_INSERT))
                begin
                    state_next = S_FINISH;
                end
                else if (link_zero && (next_free_reg >= FREE_BITS'(NODE_COUNT)))
                begin
                    state_next = S_FINISH;
                end
                else if ((op_reg == OP_INSERT) || (op_reg == OP_ERASE))
                begin
                    state_next = S_UPDATE;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_UPDATE:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                state_next = last_reg ? S_RESULT : S_IDLE;
            end
            S_RESULT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory and count unit controls
    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = slot_reg;
        link_wdata = next_free_reg[NODE_BITS-1:0];
        pre_we     = 1'b0;
        pre_waddr  = cursor_reg;
        pre_wdata  = sat_out;
        pre_raddr  = cursor_reg;
        end_we     = 1'b0;
        end_waddr  = cursor_reg;
        end_wdata  = sat_out;
        sat_in     = pre_rdata;
        sat_dec    = (op_reg == OP_ERASE);
        unique case (state_reg)
            S_CLEAR:
            begin
                link_we    = 1'b1;
                link_waddr = clear_idx_reg;
                link_wdata = '0;
                pre_we     = clear_counts;
                pre_waddr  = clear_idx_reg[NODE_BITS-1:0];
                pre_wdata  = '0;
                end_we     = clear_counts;
                end_waddr  = clear_idx_reg[NODE_BITS-1:0];
                end_wdata  = '0;
            end
            S_DECIDE:
            begin
                pre_raddr = nxt;
                link_we   = link_zero && (op_reg == OP_INSERT)
                            && (next_free_reg < FREE_BITS'(NODE_COUNT));
            end
            S_UPDATE:
            begin
                pre_we = 1'b1;
            end
            S_RESULT:
            begin
                sat_in = end_rdata;
                end_we = word_ok && ((op_reg == OP_INSERT) || (op_reg == OP_ERASE));
            end
            default:
            begin
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        clear_idx_next = clear_idx_reg;
        next_free_next = next_free_reg;
        cursor_next    = cursor_reg;
        broken_next    = broken_reg;
        full_next      = full_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        slot_next      = slot_reg;
        done_next      = 1'b0;
        count_next     = count_reg;
        status_next    = status_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clear_idx_next = clear_idx_reg + LINK_ADDR_BITS'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = op_t'(op);
                    last_next = last;
                    slot_next = LINK_ADDR_BITS'(cursor_reg) * LINK_ADDR_BITS'(ALPHABET_SIZE)
                                + LINK_ADDR_BITS'(symbol);
                    if (!broken_reg && !full_reg && bad_sym)
                    begin
                        broken_next = 1'b1;
                    end
                end
            end
            S_DECIDE:
            begin
                if (link_zero && (op_reg != OP_INSERT))
                begin
                    broken_next = 1'b1;
                end
                else if (link_zero && (next_free_reg >= FREE_BITS'(NODE_COUNT)))
                begin
                    full_next = 1'b1;
                end
                else
                begin
                    cursor_next = nxt;
                    if (link_zero)
                    begin
                        next_free_next = next_free_reg + FREE_BITS'(1);
                    end
                end
            end
            S_RESULT:
            begin
                done_next   = 1'b1;
                cursor_next = '0;
                broken_next = 1'b0;
                full_next   = 1'b0;
                if (full_reg)
                begin
                    status_next = STATUS_FULL;
                    count_next  = '0;
                end
                else if (broken_reg)
                begin
                    status_next = STATUS_MISSING;
                    count_next  = '0;
                end
                else
                begin
                    status_next = STATUS_OK;
                    case (op_reg)
                        OP_EXACT:  count_next = end_rdata;
                        OP_PREFIX: count_next = pre_rdata;
                        default:   count_next = '0;
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clear_idx_reg <= '0;
            next_free_reg <= FREE_BITS'(1);
            cursor_reg    <= '0;
            broken_reg    <= 1'b0;
            full_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_idx_reg <= clear_idx_next;
            next_free_reg <= next_free_next;
            cursor_reg    <= cursor_next;
            broken_reg    <= broken_next;
            full_reg      <= full_next;
            done_reg      <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        last_reg   <= last_next;
        slot_reg   <= slot_next;
        count_reg  <= count_next;
        status_reg <= status_next;
    end

    // result ports
    assign done   = done_reg;
    assign count  = count_reg[15:0];
    assign status = status_reg;

    // checks
    a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_RESULT))
        else $error("done strobe without a finished word");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done strobe while busy");

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg <= FREE_BITS'(NODE_COUNT))
        else $error("node allocation beyond pool");

    a_fail_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STATUS_OK)) |-> (count == '0))
        else $error("nonzero count on a failed word");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ptrie_pkg::*;

    // one letter of a word as it goes to the block
    typedef struct packed {
        op_t        op;
        logic [4:0] sym;
        logic       last;
    } letter_t;

    // one word result as the trie should report it
    typedef struct packed {
        logic [15:0] count;
        status_t     status;
    } word_result_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    op_t         op = OP_INSERT;
    logic [4:0]  symbol = '0;
    logic        last = 1'b0;
    logic        done;
    logic [15:0] count;
    logic [1:0]  status;

    prefix_counting_trie DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .op     (op),
        .symbol (symbol),
        .last   (last),
        .done   (done),
        .count  (count),
        .status (status)
    );

    // predicted trie contents
    logic [NODE_BITS-1:0]  link_mem [LINK_DEPTH] = '{default: '0};
    logic [COUNT_BITS-1:0] end_cnt [NODE_COUNT] = '{default: '0};
    logic [COUNT_BITS-1:0] pre_cnt [NODE_COUNT] = '{default: '0};
    logic [FREE_BITS-1:0]  free_ptr = FREE_BITS'(1);
    logic [NODE_BITS-1:0]  cur_node = '0;
    logic                  walk_broken = 1'b0;
    logic                  walk_full = 1'b0;

    letter_t      letter_queue [$];
    word_result_t expected_results [$];
    letter_t      next_letter;
    word_result_t want;

    logic idle_on = 1'b1;
    int   letters_queued = 0;
    int   letters_sent = 0;
    int   words_checked = 0;
    int   full_results = 0;
    int   missing_results = 0;
    int   mismatch_count = 0;
    logic [15:0] top_count = '0;

    wire letter_taken = start && !busy;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop for a hung run
    initial
    begin
        #10_000_000;
        $display("timeout: %0d letters still queued, %0d results outstanding",
                 letter_queue.size(), expected_results.size());
        $display("Verification failed");
        $finish;
    end

    function automatic logic [COUNT_BITS-1:0] sat_up(input logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_down(input logic [COUNT_BITS-1:0] v);
        return (v == '0) ? v : v - 1'b1;
    endfunction

    // walk one letter through the predicted trie, closing the word on last
    task automatic trie_step(input op_t l_op, input logic [4:0] l_sym, input logic l_last);
        int                   slot;
        logic [NODE_BITS-1:0] nxt;
        word_result_t         res;
        if (!walk_broken && !walk_full) begin
            if (l_sym >= ALPHABET_SIZE) begin
                walk_broken = 1'b1;
            end
            else begin
                slot = int'(cur_node) * ALPHABET_SIZE + int'(l_sym);
                nxt  = link_mem[slot];
                if (nxt == '0 && l_op != OP_INSERT) begin
                    walk_broken = 1'b1;
                end
                else if (nxt == '0 && free_ptr >= NODE_COUNT) begin
                    walk_full = 1'b1;
                end
                else begin
                    // allocate a fresh node on a missing link
                    if (nxt == '0) begin
                        nxt = free_ptr[NODE_BITS-1:0];
                        free_ptr = free_ptr + 1'b1;
                        link_mem[slot] = nxt;
                    end
                    cur_node = nxt;
                    if (l_op == OP_INSERT)
                        pre_cnt[nxt] = sat_up(pre_cnt[nxt]);
                    else if (l_op == OP_ERASE)
                        pre_cnt[nxt] = sat_down(pre_cnt[nxt]);
                end
            end
        end
        if (l_last) begin
            res.count  = '0;
            res.status = STATUS_OK;
            if (walk_full) begin
                res.status = STATUS_FULL;
            end
            else if (walk_broken) begin
                res.status = STATUS_MISSING;
            end
            else begin
                case (l_op)
                    OP_INSERT: end_cnt[cur_node] = sat_up(end_cnt[cur_node]);
                    OP_EXACT:  res.count = end_cnt[cur_node];
                    OP_PREFIX: res.count = pre_cnt[cur_node];
                    OP_ERASE:  end_cnt[cur_node] = sat_down(end_cnt[cur_node]);
                endcase
            end
            expected_results.push_back(res);
            cur_node    = '0;
            walk_broken = 1'b0;
            walk_full   = 1'b0;
        end
    endtask

    // driver: present letters from the queue, idling at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start    <= 1'b0;
            op       <= OP_INSERT;
            symbol   <= '0;
            last     <= 1'b0;
        end
        else begin
            if (letter_taken) begin
                trie_step(op, symbol, last);
                letters_sent++;
            end
            if (!start || letter_taken) begin
                if (letter_queue.size() != 0 && idle_on && $urandom_range(99) < 34) begin
                    start    <= 1'b0;
                end
                else if (letter_queue.size() != 0) begin
                    next_letter = letter_queue.pop_front();
                    start  <= 1'b1;
                    op     <= next_letter.op;
                    symbol <= next_letter.sym;
                    last   <= next_letter.last;
                end
                else begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic report_bad(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: got count %0d status %0d, expected count %0d status %0d",
                     $realtime, what, count, status, want.count, want.status);
    endtask

    // monitor: every result strobe must match the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                want = '0;
                report_bad("result with nothing outstanding");
            end
            else begin
                want = expected_results.pop_front();
                words_checked++;
                if (want.status == STATUS_FULL)
                    full_results++;
                if (want.status == STATUS_MISSING)
                    missing_results++;
                if (want.count > top_count)
                    top_count = want.count;
                if (count !== want.count || status !== want.status)
                    report_bad("result mismatch");
            end
        end
    end

    task automatic queue_letter(input op_t l_op, input logic [4:0] l_sym, input logic l_last);
        letter_queue.push_back('{op: l_op, sym: l_sym, last: l_last});
        letters_queued++;
    endtask

    // block until every queued letter is taken and every result is back
    task automatic wait_idle;
        while (letter_queue.size() != 0 || start || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // stimulus
    initial
    begin
        logic [4:0] dict_sym [64][8];
        int         dict_len [64];
        int         dict_n;
        logic [4:0] w_sym [8];
        int         w_len;
        int         pick;
        int         roll;
        int         k;
        op_t        w_op;
        logic       noisy;

        dict_n = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single letter word, then both queries on it
        queue_letter(OP_INSERT, 5'd0, 1'b1);
        queue_letter(OP_EXACT, 5'd0, 1'b1);
        queue_letter(OP_PREFIX, 5'd0, 1'b1);
        // two letter word sharing the first node
        queue_letter(OP_INSERT, 5'd0, 1'b0);
        queue_letter(OP_INSERT, 5'd1, 1'b1);
        queue_letter(OP_PREFIX, 5'd0, 1'b1);
        queue_letter(OP_EXACT, 5'd0, 1'b0);
        queue_letter(OP_EXACT, 5'd1, 1'b1);
        // query running past the end of the stored path
        queue_letter(OP_EXACT, 5'd0, 1'b0);
        queue_letter(OP_EXACT, 5'd1, 1'b0);
        queue_letter(OP_EXACT, 5'd2, 1'b1);
        // erase twice, end count stops at zero
        queue_letter(OP_ERASE, 5'd0, 1'b0);
        queue_letter(OP_ERASE, 5'd1, 1'b1);
        queue_letter(OP_ERASE, 5'd0, 1'b0);
        queue_letter(OP_ERASE, 5'd1, 1'b1);
        // letter outside the alphabet on insert, first and later position
        queue_letter(OP_INSERT, 5'd31, 1'b1);
        queue_letter(OP_INSERT, 5'd0, 1'b0);
        queue_letter(OP_INSERT, 5'd26, 1'b1);
        // missing path, then a letter after the break
        queue_letter(OP_ERASE, 5'd16, 1'b1);
        queue_letter(OP_PREFIX, 5'd16, 1'b0);
        queue_letter(OP_PREFIX, 5'd25, 1'b1);
        // highest letter
        queue_letter(OP_INSERT, 5'd25, 1'b1);
        wait_idle();

        // random words over a narrow alphabet, mostly reusing stored words
        while (letters_queued < 200) begin
            roll = $urandom_range(99);
            w_op = (roll < 35) ? OP_INSERT : (roll < 55) ? OP_EXACT :
                   (roll < 75) ? OP_PREFIX : OP_ERASE;
            if (dict_n != 0 && $urandom_range(99) < 60) begin
                pick  = $urandom_range(dict_n - 1);
                w_len = dict_len[pick];
                if ($urandom_range(3) == 0)
                    w_len = $urandom_range(w_len, 1);
                for (k = 0; k < w_len; k++)
                    w_sym[k] = dict_sym[pick][k];
                if ($urandom_range(4) == 0 && w_len < 8) begin
                    w_sym[w_len] = 5'($urandom_range(5));
                    w_len++;
                end
            end
            else begin
                w_len = $urandom_range(6, 1);
                for (k = 0; k < w_len; k++)
                    w_sym[k] = 5'($urandom_range(5));
            end
            if ($urandom_range(99) < 6)
                w_sym[$urandom_range(w_len - 1)] = 5'($urandom_range(31, 26));
            if (w_op == OP_INSERT && dict_n < 64) begin
                for (k = 0; k < w_len; k++)
                    dict_sym[dict_n][k] = w_sym[k];
                dict_len[dict_n] = w_len;
                dict_n++;
            end
            noisy = ($urandom_range(99) < 10);
            for (k = 0; k < w_len; k++)
                queue_letter(noisy ? op_t'($urandom_range(3)) : w_op, w_sym[k],
                             k == w_len - 1);
        end
        wait_idle();

        // long run of one word with no gaps, then queries on its counts
        idle_on = 1'b0;
        repeat (60)
            queue_letter(OP_INSERT, 5'd25, 1'b1);
        queue_letter(OP_EXACT, 5'd25, 1'b1);
        queue_letter(OP_PREFIX, 5'd25, 1'b1);
        queue_letter(OP_ERASE, 5'd25, 1'b1);
        queue_letter(OP_EXACT, 5'd25, 1'b1);
        queue_letter(OP_PREFIX, 5'd25, 1'b1);
        wait_idle();
        idle_on = 1'b1;

        // long random inserts until the node pool runs out
        while (free_ptr < NODE_COUNT) begin
            repeat (8) begin
                for (k = 0; k < 8; k++)
                    queue_letter(OP_INSERT, 5'($urandom_range(25)), k == 7);
            end
            wait_idle();
        end

        // traffic on a full pool: new paths fail, existing ones still work
        queue_letter(OP_INSERT, 5'd25, 1'b1);
        queue_letter(OP_EXACT, 5'd25, 1'b1);
        repeat (40) begin
            w_op  = op_t'($urandom_range(3));
            w_len = $urandom_range(4, 1);
            for (k = 0; k < w_len; k++)
                queue_letter(w_op, 5'($urandom_range(25)), k == w_len - 1);
        end
        wait_idle();

        // catch any stray strobe after the last result
        repeat (20) @(negedge clk);

        $display("covered %0d letters in %0d words, %0d of %0d nodes allocated",
                 letters_sent, words_checked, free_ptr - 1, NODE_COUNT - 1);
        $display("%0d pool-full and %0d missing-path results, highest count %0d",
                 full_results, missing_results, top_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end
        else begin
            $display("%0d failing results", mismatch_count);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
